>>> src/lkme_pkg.sv
`default_nettype none
package lkme_pkg;

	localparam int IDX_W     = 10;
	localparam int DIM_W     = 2;
	localparam int COORD_W   = 20;
	localparam int CFG_W     = 3;
	localparam int KV_W      = 24;
	localparam int S_TDATA_W = 48;

	localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

	localparam int NUM_POINTS_DEF = 1024;
	localparam int MAX_DIMS_DEF   = 4;

	// Sum of up to four squares of 21-bit differences, its root, the divider operands.
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 2 * COORD_W;
	localparam int SUM_W  = 44;
	localparam int ROOT_W = SUM_W / 2;
	localparam int DEN_W  = 29;
	localparam int NUM_W  = 37;
	localparam int REMH_W = NUM_W - KV_W;

	localparam logic [DEN_W-1:0] DEN_MULT   = 29'd125;
	localparam logic [DEN_W-1:0] DEN_OFFSET = 29'd8192;
	localparam logic [NUM_W-1:0] NUM_SCALED = 37'd134217728000;

endpackage
`default_nettype wire

>>> src/lkme_root_recip.sv
`default_nettype none
module lkme_root_recip
	import lkme_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start_valid,
	output logic                  start_ready,
	input  wire logic [SUM_W-1:0] sum,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [KV_W-1:0]       res
);

	typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_DEN, ST_NUM, ST_DIV, ST_DONE} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [SUM_W-1:0]   rad_q;
	logic [ROOT_W+1:0]  rrem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W:0]     drem_q;
	logic [KV_W-1:0]    quo_q;

	logic [ROOT_W+1:0]  rtry;
	logic [ROOT_W+1:0]  rtrial;
	logic [NUM_W-1:0]   num;
	logic [DEN_W:0]     dtry;

	assign rtry   = {rrem_q[ROOT_W-1:0], rad_q[SUM_W-1 -: 2]};
	assign rtrial = {root_q, 2'b01};
	assign num    = NUM_SCALED + NUM_W'(den_q >> 1);
	assign dtry   = {drem_q[DEN_W-1:0], quo_q[KV_W-1]};

	assign start_ready = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_DONE);
	assign res         = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_valid) begin
						rad_q   <= sum;
						rrem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= 5'(ROOT_W - 1);
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					// one root bit per cycle, two radicand bits in
					if (rtry >= rtrial) begin
						rrem_q <= rtry - rtrial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rrem_q <= rtry;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					rad_q <= rad_q << 2;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q   <= DEN_MULT * DEN_W'(root_q) + DEN_OFFSET;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					// upper numerator bits stay below den: quotient fits KV_W bits
					drem_q  <= (DEN_W+1)'(num[NUM_W-1 -: REMH_W]);
					quo_q   <= num[KV_W-1:0];
					cnt_q   <= 5'(KV_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dtry >= {1'b0, den_q}) begin
						drem_q <= dtry - {1'b0, den_q};
						quo_q  <= {quo_q[KV_W-2:0], 1'b1};
					end else begin
						drem_q <= dtry;
						quo_q  <= {quo_q[KV_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/laplace_kernel_matrix_entry_unit.sv
// Load item: written to the point memory at the edge that accepts it; no result.
// Compute item: one memory read of both points per dimension, a 22-step root loop,
// a 24-step divide loop, then the output register.
// After a compute item the input takes a new item once its sum is handed to the root/divide
// unit; loads go on while that unit works, and the next compute waits until the unit is free.
// Reset (arst_n low, asynchronous): control cleared, active_dims = 3; memory not cleared.
`default_nettype none
module laplace_kernel_matrix_entry_unit
	import lkme_pkg::*;
#(
	parameter int NUM_POINTS = NUM_POINTS_DEF,
	parameter int MAX_DIMS   = MAX_DIMS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr,
	input  wire logic [CFG_W-1:0]     cfg_data,     // active_dims
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// point_index[9:0], dimension[11:10], coordinate[31:12], other_point_index[41:32]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [0:0]           s_tuser,      // command: 0 load, 1 compute
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [KV_W-1:0]           m_tdata       // kernel_value
);

	localparam int PW = $clog2(NUM_POINTS);
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW = $clog2(NUM_POINTS * MAX_DIMS);
	localparam int DEPTH = NUM_POINTS * MAX_DIMS;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DRAIN} state_t;

	// Wrap a point index into the store by conditional subtraction of shifted depths.
	function automatic logic [PW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] x;
		x = v;
		for (int s = IDX_W - 1; s >= 0; s--) begin
			if ((NUM_POINTS << s) < (1 << IDX_W)) begin
				if (x >= IDX_W'(NUM_POINTS << s)) x = x - IDX_W'(NUM_POINTS << s);
			end
		end
		return PW'(x);
	endfunction

	// Unpack the item.
	logic [IDX_W-1:0]          in_row;
	logic [DIM_W-1:0]          in_dim;
	logic [COORD_W-1:0]        in_coord;
	logic [IDX_W-1:0]          in_col;
	logic                      accept;

	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_dim   = s_tdata[IDX_W +: DIM_W];
	assign in_coord = s_tdata[IDX_W+DIM_W +: COORD_W];
	assign in_col   = s_tdata[IDX_W+DIM_W+COORD_W +: IDX_W];
	assign accept   = s_tvalid && s_tready;

	// Configuration: active_dims, clamped to 1..MAX_DIMS when a compute item starts.
	logic [CFG_W-1:0] dims_q;
	logic [DW-1:0]    last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dims_q <= CFG_RESET;
		else if (cfg_wr) dims_q <= cfg_data;
	end

	always_comb begin
		if (dims_q == '0) last_k = '0;
		else if (int'(dims_q) > MAX_DIMS) last_k = DW'(MAX_DIMS - 1);
		else last_k = DW'(dims_q - 3'd1);
	end

	// Point memory: one write port for loads, two read ports for the row and column points.
	logic [COORD_W-1:0] mem [DEPTH];
	logic [AW-1:0]      wr_addr;
	logic               wr_en;
	logic [AW-1:0]      row_base_q;
	logic [AW-1:0]      col_base_q;
	logic [DW-1:0]      k_q;
	logic [DW-1:0]      kl_q;
	state_t             state_q;
	logic [COORD_W-1:0] rd_a_s1;
	logic [COORD_W-1:0] rd_b_s1;
	logic               rd_vld_s1;

	assign wr_addr = AW'(int'(wrap_idx(in_row)) * MAX_DIMS) + AW'(in_dim);
	assign wr_en   = accept && (s_tuser[0] == 1'b0) && (int'(in_dim) < MAX_DIMS);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= in_coord;
		if (state_q == ST_READ) begin
			rd_a_s1 <= mem[row_base_q + AW'(k_q)];
			rd_b_s1 <= mem[col_base_q + AW'(k_q)];
		end
	end

	// Square each difference, then accumulate.
	logic signed [DIFF_W-1:0] diff;
	logic [COORD_W:0]         mag;
	logic [SQ_W:0]            sq_s2;
	logic                     sq_vld_s2;
	logic [SUM_W-1:0]         acc_q;

	assign diff = DIFF_W'($signed(rd_a_s1)) - DIFF_W'($signed(rd_b_s1));
	assign mag  = diff[DIFF_W-1] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) sq_s2 <= (SQ_W+1)'(mag * mag);
	end

	// Root/reciprocal unit handshake.
	logic            st_valid;
	logic            st_ready;
	logic            rr_valid;
	logic            rr_ready;
	logic [KV_W-1:0] rr_value;

	assign st_valid = (state_q == ST_DRAIN) && !rd_vld_s1 && !sq_vld_s2;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			sq_vld_s2 <= rd_vld_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser[0]) begin
						row_base_q <= AW'(int'(wrap_idx(in_row)) * MAX_DIMS);
						col_base_q <= AW'(int'(wrap_idx(in_col)) * MAX_DIMS);
						kl_q       <= last_k;
						k_q        <= '0;
						acc_q      <= '0;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					// issue one dimension per cycle
					k_q <= k_q + DW'(1);
					if (k_q == kl_q) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// hold until the sum is complete and the unit is free
					if (st_valid && st_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (sq_vld_s2) acc_q <= acc_q + SUM_W'(sq_s2);
		end
	end

	lkme_root_recip u_root_recip (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (st_valid),
		.start_ready (st_ready),
		.sum         (acc_q),
		.res_valid   (rr_valid),
		.res_ready   (rr_ready),
		.res         (rr_value)
	);

	// Output register: the unit holds its result until this slot frees.
	logic            m_valid_q;
	logic [KV_W-1:0] m_data_q;

	assign rr_ready = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (rr_ready) begin
			m_valid_q <= rr_valid;
			if (rr_valid) m_data_q <= rr_value;
		end
	end

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
class kernel_scoreboard;
	logic signed [19:0] coords [0:1023][0:3];
	logic [2:0] dims_reg;
	logic [23:0] pending_values [$];
	int errors;

	function new();
		dims_reg = 3'd3;
		errors = 0;
	endfunction

	// Square root of the sum of squared differences, floored.
	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void note_item(bit cmd, logic [47:0] data);
		int unsigned row;
		int unsigned col;
		int unsigned n;
		longint signed diff;
		longint unsigned sum;
		longint unsigned d;
		longint unsigned den;
		longint unsigned q;
		row = data[9:0];
		col = data[41:32];
		if (cmd == 1'b0) begin
			coords[row][data[11:10]] = data[31:12];
			return;
		end
		n = dims_reg;
		if (n < 1) n = 1;
		if (n > 4) n = 4;
		sum = 0;
		for (int k = 0; k < n; k++) begin
			diff = longint'(coords[row][k]) - longint'(coords[col][k]);
			if (diff < 0) diff = -diff;
			sum += longint'(diff) * longint'(diff);
		end
		d = root_floor(sum);
		den = 125 * d + 8192;
		q = ((64'd125 << 30) + den / 2) / den;
		if (q > 64'hFFFFFF) q = 64'hFFFFFF;
		pending_values.push_back(q[23:0]);
	endfunction

	function automatic void check_value(logic [23:0] actual);
		logic [23:0] want;
		if (pending_values.size() == 0) begin
			$display("%0t: kernel_value with none expected: actual %0d", $time, actual);
			errors++;
			return;
		end
		want = pending_values.pop_front();
		if (actual !== want) begin
			$display("%0t: kernel_value mismatch: expected %0d actual %0d",
				$time, want, actual);
			errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lkme_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	// Idle slack after the last expected result; allow plenty of it.
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0; // point_index, dimension, coordinate, other_point_index
	logic [0:0] s_tuser = '0;           // command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [KV_W-1:0] m_tdata;           // kernel_value

	kernel_scoreboard board;
	int unsigned cycle_count = 0;
	bit sink_quiet = 1'b0;     // no random stalls on the result side
	bit sink_hold = 1'b0;      // long hold-off to fill the block
	bit hold_go = 1'b0;        // start the hold-off once items stream
	bit source_quiet = 1'b0;
	logic [9:0] live_points [$];

	always #1 clk = ~clk;

	laplace_kernel_matrix_entry_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Check every accepted result; randomly stall the result side.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && m_tvalid && m_tready) board.check_value(m_tdata);
		if (sink_hold) m_tready <= 1'b0;
		else m_tready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 16);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one item, idle at random beforehand, hold until accepted.
	// tvalid stays high after the accept; the next item replaces it or wait_idle drops it.
	task automatic send_item(bit cmd, logic [9:0] row, logic [1:0] dim,
		logic [19:0] coord, logic [9:0] col);
		while (!source_quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, col, coord, dim, row};
		do @(posedge clk); while (!s_tready);
		board.note_item(cmd, {6'd0, col, coord, dim, row});
	endtask

	task automatic load_point(logic [9:0] row, logic [19:0] c0, logic [19:0] c1,
		logic [19:0] c2, logic [19:0] c3);
		send_item(1'b0, row, 2'd0, c0, 10'($urandom));
		send_item(1'b0, row, 2'd1, c1, 10'($urandom));
		send_item(1'b0, row, 2'd2, c2, 10'($urandom));
		send_item(1'b0, row, 2'd3, c3, 10'($urandom));
		live_points.push_back(row);
	endtask

	function automatic logic [9:0] pick_point();
		return live_points[$urandom_range(live_points.size() - 1)];
	endfunction

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [2:0] value);
		wait_idle();
		cfg_wr <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		board.dims_reg = value;
		cfg_wr <= 1'b0;
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30)
				send_item(1'b0, pick_point(), 2'($urandom), 20'($urandom), 10'($urandom));
			else
				send_item(1'b1, pick_point(), 2'($urandom), 20'($urandom), pick_point());
		end
	endtask

	// Hold the result side off long enough for the input to back up.
	initial begin
		wait (hold_go);
		repeat (50) @(posedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme coordinates, the far corner of the index range.
		load_point(10'd0, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
		load_point(10'd1023, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
		load_point(10'd512, 20'h80000, 20'h80000, 20'h80000, 20'h80000);
		load_point(10'd5, 20'h00001, 20'hFFFFF, 20'h55555, 20'hAAAAA);
		send_item(1'b1, 10'd0, 2'd0, 20'd0, 10'd0);       // zero distance, largest value
		send_item(1'b1, 10'd1023, 2'd3, 20'hFFFFF, 10'd512); // largest distance
		send_item(1'b1, 10'd512, 2'd1, 20'd0, 10'd1023);
		send_item(1'b1, 10'd5, 2'd2, 20'd0, 10'd0);
		send_item(1'b1, 10'd0, 2'd0, 20'd0, 10'd5);
		for (int v = 0; v < 8; v++) begin
			write_dims(v[2:0]); // zero acts as one, above four as four
			send_item(1'b1, 10'd1023, 2'd0, 20'd0, 10'd512);
			send_item(1'b1, 10'd5, 2'd0, 20'd0, 10'd1023);
		end
		write_dims(3'd3);

		// Random: fill more points, then mix loads and computes.
		for (int p = 0; p < 40; p++) load_point(10'($urandom), 20'($urandom), 20'($urandom),
			20'($urandom), 20'($urandom));
		hold_go = 1'b1;
		random_phase(300);
		write_dims(3'd1);
		source_quiet = 1'b1;
		sink_quiet = 1'b1;
		random_phase(150);
		source_quiet = 1'b0;
		sink_quiet = 1'b0;
		write_dims(3'd4);
		random_phase(250);
		write_dims(3'($urandom_range(2, 3)));
		random_phase(200);

		wait_idle();
		if (board.errors == 0 && board.pending_values.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
src/lkme_pkg.sv
src/lkme_root_recip.sv
src/laplace_kernel_matrix_entry_unit.sv
dv/testbench.sv
